// ===== rtl/lru_key_value_cache_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LRU key/value cache
// Concurrent assertion wrappers with a clock, a reset and an error message.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// Generic form: explicit clock and active-low reset
`define LKV_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Default form: block clock and reset
`define LKV_ASSERT(label, prop, msg) \
    `LKV_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Payload types, cell control structs, states and constants.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // Request transaction
    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value_in;
    } t_req;

    // Response transaction
    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] value_out;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } t_rsp;

    // Configuration write
    typedef struct packed {
        logic [CAP_W-1:0] capacity;
    } t_cfg;

    // One cache entry as held in a cell
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             valid;
    } t_entry;

    // Lookup broadcast to every cell
    typedef struct packed {
        logic             look;
        logic [KEY_W-1:0] key;
    } t_probe;

    // Update broadcast to every cell
    typedef struct packed {
        logic upd;
        logic hit;
        logic insert;
        logic evict;
    } t_upd;

    // Results gathered along the row of cells
    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] hit_value;
        logic [KEY_W-1:0] lru_key;
    } t_gather;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

endpackage

// ===== rtl/lkv_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel carrying a typed payload with a source and a sink view.
// ----------------------------------------------------------------------------
interface lkv_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative get/set store kept as a row of cells ordered by recency.
// ----------------------------------------------------------------------------
//  channel  direction  payload                                   handshake
//  i_req    in         cmd, key, value_in                        valid/ready
//  o_rsp    out        hit, value_out, evicted, evicted_key      valid/ready
//  i_cfg    in         capacity                                  valid/ready
//
//  Per transaction, the accept cycle compares the key in every
//  cell and gathers hit value and LRU key; the update cycle shifts the row.
//  The row update waits while the response register is still occupied.
//  Reset empties the cache; capacity resets to 16.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lkv_stream_if.sink   i_req,
    lkv_stream_if.source o_rsp,
    lkv_stream_if.sink   i_cfg
);
    localparam int FW = $clog2(ENTRIES + 1);
    localparam int CW = (FW > CAP_W) ? FW : CAP_W;

    t_state           r_state;
    t_state           n_state;
    logic [CAP_W-1:0] r_cap;
    logic [FW-1:0]    r_fill;
    logic             r_out_valid;
    t_rsp             r_rsp;

    logic             r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic             r_hit;
    logic [VAL_W-1:0] r_hit_value;
    logic [KEY_W-1:0] r_lru_key;
    logic             r_full;

    logic             w_accept;
    logic             w_can_load;
    logic             w_upd;
    logic             w_insert;
    logic             w_evict;
    logic [CW-1:0]    w_cap_ext;
    logic [CW-1:0]    w_eff_cap;
    t_probe           w_probe;
    t_upd             w_ctl;
    t_entry           w_new;
    t_entry           w_ent   [ENTRIES];
    logic             w_mchain[ENTRIES+1];
    t_gather          w_acc   [ENTRIES+1];

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_can_load = !r_out_valid || o_rsp.ready;

    // Capacity clamped to 1..ENTRIES
    always_comb begin
        w_cap_ext = CW'(r_cap);
        if (r_cap == '0) begin
            w_eff_cap = CW'(1);
        end else if (w_cap_ext > CW'(ENTRIES)) begin
            w_eff_cap = CW'(ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_req.ready = 1'b0;
        w_upd       = 1'b0;
        case (r_state)
            S_IDLE:  i_req.ready = 1'b1;
            S_UPD:   w_upd       = w_can_load;
            default: ;
        endcase
    end

    // Row control
    assign w_insert = (r_cmd == CMD_SET) && !r_hit && !r_full;
    assign w_evict  = (r_cmd == CMD_SET) && !r_hit && r_full;
    assign w_probe  = '{look: w_accept, key: i_req.data.key};
    assign w_ctl    = '{upd: w_upd, hit: r_hit, insert: w_insert, evict: w_evict};

    // Entry entering at the most recent rank
    assign w_new = '{key: r_key,
                     value: (r_cmd == CMD_SET) ? r_val : r_hit_value,
                     valid: 1'b1};

    assign w_mchain[ENTRIES] = 1'b0;
    assign w_acc[ENTRIES]    = '0;

    // Row of cells, rank 0 most recent
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_probe  (w_probe),
            .i_upd    (w_ctl),
            .i_fill   (r_fill),
            .i_prev   ((g == 0) ? w_new : w_ent[(g == 0) ? 0 : g - 1]),
            .o_entry  (w_ent[g]),
            .i_mchain (w_mchain[g+1]),
            .o_mchain (w_mchain[g]),
            .i_acc    (w_acc[g+1]),
            .o_acc    (w_acc[g])
        );
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data.capacity;
            end
            if (w_upd && w_insert) begin
                r_fill <= r_fill + FW'(1);
            end
            if (w_upd) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Lookup results captured at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= i_req.data.cmd;
            r_key       <= i_req.data.key;
            r_val       <= i_req.data.value_in;
            r_hit       <= w_acc[0].hit;
            r_hit_value <= w_acc[0].hit_value;
            r_lru_key   <= w_acc[0].lru_key;
            r_full      <= (CW'(r_fill) >= w_eff_cap);
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_rsp.hit         <= r_hit;
            r_rsp.value_out   <= ((r_cmd == CMD_GET) && r_hit) ? r_hit_value : '0;
            r_rsp.evicted     <= w_evict;
            r_rsp.evicted_key <= w_evict ? r_lru_key : '0;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;
    assign i_cfg.ready = 1'b1;

endmodule

// ===== rtl/lkv_cell.sv =====
// ----------------------------------------------------------------------------
// LRU cache cell
// Holds one entry at a fixed recency rank; takes its neighbour's entry when
// the row shifts, compares its key and adds its part to the gathered results.
// ----------------------------------------------------------------------------
module lkv_cell
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IDX     = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_probe                           i_probe,
    input  t_upd                             i_upd,
    input  logic [$clog2(ENTRIES+1)-1:0]     i_fill,
    input  t_entry                           i_prev,
    output t_entry                           o_entry,
    input  logic                             i_mchain,
    output logic                             o_mchain,
    input  t_gather                          i_acc,
    output t_gather                          o_acc
);
    localparam int FW = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic             r_valid;
    logic             r_match;
    logic             w_match;
    logic             w_last;
    logic             w_below_fill;
    logic             w_shift;

    // Key compare against the broadcast lookup key
    assign w_match      = r_valid && (r_key == i_probe.key);
    assign w_last       = (FW'(IDX + 1) == i_fill);
    assign w_below_fill = (FW'(IDX) < i_fill);

    // Hit at this rank or any older rank
    assign o_mchain = r_match | i_mchain;

    // Shift in from the younger neighbour
    always_comb begin
        w_shift = 1'b0;
        if (i_upd.upd) begin
            if (i_upd.hit) begin
                w_shift = o_mchain;
            end else begin
                w_shift = i_upd.insert | (i_upd.evict & w_below_fill);
            end
        end
    end

    // Gather: any hit, the hit value, and the key at the oldest valid rank
    always_comb begin
        o_acc.hit       = i_acc.hit | w_match;
        o_acc.hit_value = i_acc.hit_value | (w_match ? r_value : '0);
        o_acc.lru_key   = i_acc.lru_key | (w_last ? r_key : '0);
    end

    assign o_entry = '{key: r_key, value: r_value, valid: r_valid};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_probe.look) begin
                r_match <= w_match;
            end
            if (w_shift) begin
                r_valid <= i_prev.valid;
            end
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

endmodule

// ===== rtl/lkv_checker.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache port checker
// Watches the top-level channels and flags response and pacing errors.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_unit_assert.svh"

module lkv_checker
    import lkv_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);
    // A waiting response stays offered
    `LKV_ASSERT(a_rsp_hold, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid, "response dropped")

    // One transaction in flight: no accept right after an accept
    `LKV_ASSERT(a_one_in_flight, i_req_valid && i_req_ready |=> !i_req_ready, "back-to-back accept")

    // Eviction only happens on a miss
    `LKV_ASSERT(a_evict_miss, i_rsp_valid |-> !(i_rsp.evicted && i_rsp.hit), "eviction on hit")

    // Miss returns a zero value
    `LKV_ASSERT(a_miss_zero, i_rsp_valid && !i_rsp.hit |-> i_rsp.value_out == '0, "miss value")

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);
